@@ hdl/crc_checked_word_deframer_assert.svh @@
// Assertion macros for the word deframer.
`ifndef CRC_CHECKED_WORD_DEFRAMER_ASSERT_SVH
`define CRC_CHECKED_WORD_DEFRAMER_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define CCWD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define CCWD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/ccwd_pkg.sv @@
`timescale 1ns / 1ps
package ccwd_pkg;

  // Largest number of words in one read
  localparam int MAX_WORDS = 4;
  localparam int WORD_W    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CNT_W     = ($clog2(MAX_WORDS + 1) > 3) ? $clog2(MAX_WORDS + 1) : 3;
  localparam int IDX_W     = 2;

  localparam logic [2:0] WORD_COUNT_RST = 3'd2;

  // CRC-8 constants
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  typedef logic [WORD_W-1:0] word_pos_t;
  typedef logic [CNT_W-1:0]  word_cnt_t;

  // Position within the current byte triple
  typedef enum logic [1:0] {
    PH_HIGH = 2'd0,
    PH_LOW  = 2'd1,
    PH_CRC  = 2'd2
  } phase_t;

  // Advance the CRC over one byte, MSB first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ hdl/crc_checked_word_deframer.sv @@
`timescale 1ns / 1ps
`include "crc_checked_word_deframer_assert.svh"
// Word deframer with CRC-8 check (poly 0x31, init 0xFF, MSB first). Bytes come
// in triples (high, low, CRC); each CRC byte yields one result carrying the
// word, its match flag, a sticky read-good flag, its index and a last-word
// mark after word_count words (0 acts as 1, above 4 acts as 4). One byte is
// taken per clock while in_ready is high; the CRC update is unrolled between
// the framing and output registers, and the result of a CRC byte is presented
// on the next cycle. in_ready falls only while a result sits in the output
// register and out_ready is low. start_req restarts the read on the byte it
// marks. word_count is written through the cfg channel, which is always ready.
module crc_checked_word_deframer (
  input  logic        clk,
  input  logic        rst,
  // byte input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        start_req,
  // word output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] word_value,
  output logic        crc_ok,
  output logic        read_ok,
  output logic [ccwd_pkg::IDX_W-1:0] word_index,
  output logic        last_word,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data
);
  import ccwd_pkg::*;

  logic [2:0]  word_count;
  phase_t      phase, phase_next;
  logic [7:0]  held_high, held_high_next;
  logic [7:0]  held_low, held_low_next;
  logic [7:0]  running_crc, running_crc_next;
  word_pos_t   current_word, current_word_next;
  logic        read_failed, read_failed_next;
  logic        out_valid_next;

  logic        accept;
  logic        emit;
  phase_t      eff_phase;
  logic [7:0]  eff_crc;
  word_pos_t   eff_word;
  logic        eff_failed;
  word_cnt_t   eff_count;
  word_cnt_t   pos_plus;
  logic        match;
  logic        is_last;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  // Take the register write
  always_ff @(posedge clk) begin
    if (rst) begin
      word_count <= WORD_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      word_count <= cfg_data;
    end
  end

  // Clamp the word count into 1..MAX_WORDS
  always_comb begin
    if (word_count == 3'd0) begin
      eff_count = word_cnt_t'(1);
    end else if (CNT_W'(word_count) > word_cnt_t'(MAX_WORDS)) begin
      eff_count = word_cnt_t'(MAX_WORDS);
    end else begin
      eff_count = CNT_W'(word_count);
    end
  end

  // Framing state as seen by this byte, after any restart
  assign eff_phase  = start_req ? PH_HIGH : phase;
  assign eff_crc    = start_req ? CRC_INIT : running_crc;
  assign eff_word   = start_req ? '0 : current_word;
  assign eff_failed = start_req ? 1'b0 : read_failed;
  assign pos_plus   = CNT_W'(eff_word) + word_cnt_t'(1);
  assign is_last    = pos_plus >= eff_count;
  assign match      = eff_crc == rx_byte;

  // Next framing state
  always_comb begin
    phase_next        = phase;
    held_high_next    = held_high;
    held_low_next     = held_low;
    running_crc_next  = running_crc;
    current_word_next = current_word;
    read_failed_next  = read_failed;
    emit              = 1'b0;
    if (accept) begin
      current_word_next = eff_word;
      read_failed_next  = eff_failed;
      unique case (eff_phase)
        PH_LOW: begin
          held_low_next    = rx_byte;
          running_crc_next = crc8_byte(eff_crc, rx_byte);
          phase_next       = PH_CRC;
        end
        PH_CRC: begin
          emit             = 1'b1;
          phase_next       = PH_HIGH;
          running_crc_next = CRC_INIT;
          if (is_last) begin
            current_word_next = '0;
            read_failed_next  = 1'b0;
          end else begin
            current_word_next = eff_word + word_pos_t'(1);
            read_failed_next  = eff_failed || !match;
          end
        end
        default: begin
          held_high_next   = rx_byte;
          running_crc_next = crc8_byte(CRC_INIT, rx_byte);
          phase_next       = PH_LOW;
        end
      endcase
    end
  end

  // Hold a result until the transaction completes
  always_comb begin
    if (emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HIGH;
      running_crc  <= CRC_INIT;
      current_word <= '0;
      read_failed  <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      phase        <= phase_next;
      running_crc  <= running_crc_next;
      current_word <= current_word_next;
      read_failed  <= read_failed_next;
      out_valid    <= out_valid_next;
    end
  end

  // Data bytes and result payload
  always_ff @(posedge clk) begin
    held_high <= held_high_next;
    held_low  <= held_low_next;
    if (emit) begin
      word_value <= {held_high, held_low};
      crc_ok     <= match;
      read_ok    <= !(eff_failed || !match);
      word_index <= IDX_W'(eff_word);
      last_word  <= is_last;
    end
  end

  `CCWD_ASSERT_NEXT(a_emit_loads_out, clk, rst, emit, out_valid,
                    "CRC byte did not produce a result")
  `CCWD_ASSERT_NEXT(a_last_restarts, clk, rst, emit && is_last,
                    phase == PH_HIGH && current_word == '0 && !read_failed,
                    "framing not restarted after last word")
  `CCWD_ASSERT_NOW(a_read_ok_needs_crc_ok, clk, rst, out_valid && read_ok, crc_ok,
                   "read flagged good on a mismatched word")

endmodule
